// ===== sv/pts_pkg.sv =====
// package for the priority tick scheduler with counting semaphores
// holds widths, codes, shared command and status structs; no dependencies
package pts_pkg;
   localparam int NUM_TASKS_DEF = 6;
   localparam int NUM_SEMS_DEF = 4;
   localparam int TASK_W = 3;
   localparam int SEM_W = 2;
   localparam int TICK_W = 8;
   localparam int SLEEP_W = 13;
   localparam int COUNT_W = 8;
   localparam int MS_W = 16;
   localparam int PRIO_W = 48;
   localparam int INIT_W = 16;
   localparam int CSR_W = 48;
   localparam int TICK_MS = 10;
   // divide by ten as multiply and shift, exact over the millisecond range
   localparam logic [MS_W-1:0] TICK_RECIP = 16'd52429;
   localparam int TICK_SHIFT = 19;
   localparam logic [TASK_W-1:0] NO_TASK = 3'd7;

   typedef enum logic [1:0] {
      KIND_SCHED = 2'd0,
      KIND_SLEEP = 2'd1,
      KIND_P     = 2'd2,
      KIND_V     = 2'd3
   } kind_type;

   localparam logic CSR_PRIO = 1'b0;
   localparam logic CSR_INIT = 1'b1;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,      // capture request, normalise current task
      OP_SLEEP_SET, // write sleep count of current task
      OP_DECAY,     // count all sleep counters down
      OP_PICK,      // pick best ready task into best register
      OP_REFILL,    // refill ready tasks from priorities
      OP_COMMIT,    // commit best (or flag none)
      OP_P_COUNT,   // decrement semaphore
      OP_P_ENQ,     // mark waiting and start walk
      OP_WALK,      // one step along waiter list
      OP_LINK,      // link tail to current
      OP_V,         // increment semaphore and wake head
      OP_DONE       // register result
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic       best_found;
      logic       p_valid;
      logic       p_blocks;
      logic       queue_empty;
      logic       walk_end;
      logic [1:0] kind;
   } status_type;
endpackage

// ===== sv/pts_if.sv =====
// valid/ready channel interface for the scheduler
// payload type is a parameter; depends on nothing
interface pts_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/pts_ctrl.sv =====
// controller state machine of the scheduler
// sequences datapath commands; uses pts_pkg
module pts_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  pts_pkg::status_type status,
   output pts_pkg::cmd_type    cmd
);
   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_SLEEP, S_DECAY, S_PICK1, S_REFILL, S_PICK2, S_COMMIT,
      S_PCOUNT, S_PENQ, S_WALK, S_LINK, S_V, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op = pts_pkg::OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.op = pts_pkg::OP_LOAD;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            case (status.kind)
               pts_pkg::KIND_SCHED: state_in = S_DECAY;
               pts_pkg::KIND_SLEEP: state_in = S_SLEEP;
               pts_pkg::KIND_P:     state_in = status.p_valid ? S_PCOUNT : S_OUT;
               default:             state_in = status.p_valid ? S_V : S_OUT;
            endcase
         end
         S_SLEEP: begin
            cmd.op = pts_pkg::OP_SLEEP_SET;
            state_in = S_DECAY;
         end
         S_DECAY: begin
            cmd.op = pts_pkg::OP_DECAY;
            state_in = S_PICK1;
         end
         S_PICK1: begin
            cmd.op = pts_pkg::OP_PICK;
            state_in = S_REFILL;
         end
         S_REFILL: begin
            if (status.best_found) begin
               state_in = S_COMMIT;
            end else begin
               cmd.op = pts_pkg::OP_REFILL;
               state_in = S_PICK2;
            end
         end
         S_PICK2: begin
            cmd.op = pts_pkg::OP_PICK;
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.op = pts_pkg::OP_COMMIT;
            state_in = S_OUT;
         end
         S_PCOUNT: begin
            cmd.op = pts_pkg::OP_P_COUNT;
            state_in = S_PENQ;
         end
         S_PENQ: begin
            if (status.p_blocks) begin
               cmd.op = pts_pkg::OP_P_ENQ;
               state_in = status.queue_empty ? S_DECAY : S_WALK;
            end else begin
               state_in = S_OUT;
            end
         end
         S_WALK: begin
            cmd.op = pts_pkg::OP_WALK;
            if (status.walk_end) state_in = S_LINK;
         end
         S_LINK: begin
            cmd.op = pts_pkg::OP_LINK;
            state_in = S_DECAY;
         end
         S_V: begin
            cmd.op = pts_pkg::OP_V;
            state_in = S_OUT;
         end
         S_OUT: begin
            cmd.op = pts_pkg::OP_DONE;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

// ===== sv/pts_dp.sv =====
// datapath of the scheduler: task table, semaphores, pick logic
// driven by pts_ctrl commands; uses pts_pkg
module pts_dp #(
   parameter int NUM_TASKS = pts_pkg::NUM_TASKS_DEF,
   parameter int NUM_SEMS = pts_pkg::NUM_SEMS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pts_pkg::cmd_type            cmd,
   output pts_pkg::status_type         status,
   input  logic                        csr_write,
   input  logic                        csr_index,
   input  logic [pts_pkg::CSR_W-1:0]   csr_data,
   input  logic [1:0]                  req_kind,
   input  logic [1:0]                  req_sem_index,
   input  logic [pts_pkg::MS_W-1:0]    req_sleep_millis,
   output logic [pts_pkg::TASK_W-1:0]  rsp_running_task,
   output logic                        rsp_none_ready,
   output logic                        rsp_caller_blocked
);
   localparam int TW = pts_pkg::TASK_W;
   localparam int SEM_IDX_W = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
   localparam int TASK_IDX_W = $clog2(NUM_TASKS);

   logic [pts_pkg::PRIO_W-1:0]  prio_ff;
   logic [pts_pkg::TICK_W-1:0]  ticks_ff [NUM_TASKS];
   logic [pts_pkg::SLEEP_W-1:0] sleep_ff [NUM_TASKS];
   logic [NUM_TASKS-1:0]        wait_ff;
   logic [TW-1:0]               next_ff  [NUM_TASKS];
   logic signed [pts_pkg::COUNT_W-1:0] count_ff [NUM_SEMS];
   logic [TW-1:0]               head_ff  [NUM_SEMS];
   logic [TW-1:0]               cur_ff;
   logic [1:0]                  kind_ff;
   logic [1:0]                  sem_ff;
   logic [pts_pkg::MS_W-1:0]    ms_ff;
   logic                        found_ff;
   logic [TW-1:0]               best_ff;
   logic                        none_ff;
   logic                        blocked_ff;
   logic [TW-1:0]               tail_ff;
   logic [TW-1:0]               out_task_ff;
   logic                        out_none_ff, out_blocked_ff;

   logic [NUM_TASKS-1:0] ready;
   logic                 pick_found;
   logic [TW-1:0]        pick_idx;
   logic [pts_pkg::TICK_W-1:0] pick_top;
   logic                 sem_ok;
   logic [SEM_IDX_W-1:0] s;
   logic [pts_pkg::SLEEP_W-1:0] sleep_val;
   logic [2*pts_pkg::MS_W-1:0]  ms_prod;
   logic [TW-1:0]        cur_n;
   logic [TW-1:0]        walk_n;
   logic [TW-1:0]        v_head, v_next;

   always_comb begin
      for (int t = 0; t < NUM_TASKS; t++)
         ready[t] = !wait_ff[t] && (sleep_ff[t] == '0);
   end

   always_comb begin
      pick_found = 1'b0;
      pick_idx = '0;
      pick_top = '0;
      for (int t = 0; t < NUM_TASKS; t++) begin
         if (ready[t] && ticks_ff[t] > pick_top) begin
            pick_top = ticks_ff[t];
            pick_idx = TW'(t);
            pick_found = 1'b1;
         end
      end
   end

   assign sem_ok = ({1'b0, sem_ff} < 3'(NUM_SEMS));
   assign s = SEM_IDX_W'(sem_ff);
   assign ms_prod = ms_ff * pts_pkg::TICK_RECIP;
   assign sleep_val = ms_prod[pts_pkg::TICK_SHIFT +: pts_pkg::SLEEP_W];
   assign cur_n = ({1'b0, cur_ff} < 4'(NUM_TASKS)) ? cur_ff : '0;
   assign walk_n = next_ff[tail_ff[TASK_IDX_W-1:0]];
   assign v_head = head_ff[s];
   assign v_next = next_ff[v_head[TASK_IDX_W-1:0]];

   assign status.kind = kind_ff;
   assign status.best_found = found_ff;
   assign status.p_valid = sem_ok && ((kind_ff == pts_pkg::KIND_V) || !wait_ff[cur_ff[TASK_IDX_W-1:0]]);
   assign status.p_blocks = count_ff[s][pts_pkg::COUNT_W-1];
   assign status.queue_empty = ({1'b0, head_ff[s]} >= 4'(NUM_TASKS));
   assign status.walk_end = ({1'b0, walk_n} >= 4'(NUM_TASKS));

   assign rsp_running_task = out_task_ff;
   assign rsp_none_ready = out_none_ff;
   assign rsp_caller_blocked = out_blocked_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prio_ff <= '0;
         for (int t = 0; t < NUM_TASKS; t++) begin
            ticks_ff[t] <= '0;
            sleep_ff[t] <= '0;
            next_ff[t] <= pts_pkg::NO_TASK;
         end
         wait_ff <= '0;
         for (int i = 0; i < NUM_SEMS; i++) begin
            count_ff[i] <= pts_pkg::COUNT_W'(init_reset_nib(i));
            head_ff[i] <= pts_pkg::NO_TASK;
         end
         cur_ff <= '0;
         found_ff <= 1'b0;
         none_ff <= 1'b0;
         blocked_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            if (csr_index == pts_pkg::CSR_PRIO) begin
               prio_ff <= csr_data[pts_pkg::PRIO_W-1:0];
            end else begin
               for (int i = 0; i < NUM_SEMS; i++)
                  count_ff[i] <= pts_pkg::COUNT_W'(csr_data[4*i +: 4]);
            end
         end
         case (cmd.op)
            pts_pkg::OP_LOAD: begin
               kind_ff <= req_kind;
               sem_ff <= req_sem_index;
               ms_ff <= req_sleep_millis;
               cur_ff <= cur_n;
               none_ff <= 1'b0;
               blocked_ff <= 1'b0;
            end
            pts_pkg::OP_SLEEP_SET: sleep_ff[cur_ff[TASK_IDX_W-1:0]] <= sleep_val;
            pts_pkg::OP_DECAY: begin
               for (int t = 0; t < NUM_TASKS; t++)
                  if (sleep_ff[t] != '0) sleep_ff[t] <= sleep_ff[t] - 1'b1;
            end
            pts_pkg::OP_PICK: begin
               found_ff <= pick_found;
               best_ff <= pick_idx;
            end
            pts_pkg::OP_REFILL: begin
               for (int t = 0; t < NUM_TASKS; t++)
                  if (ready[t]) ticks_ff[t] <= prio_ff[8*t +: 8];
            end
            pts_pkg::OP_COMMIT: begin
               if (found_ff) cur_ff <= best_ff;
               else none_ff <= 1'b1;
            end
            pts_pkg::OP_P_COUNT: begin
               if (count_ff[s] != -8'sd128) count_ff[s] <= count_ff[s] - 1'b1;
            end
            pts_pkg::OP_P_ENQ: begin
               wait_ff[cur_ff[TASK_IDX_W-1:0]] <= 1'b1;
               next_ff[cur_ff[TASK_IDX_W-1:0]] <= pts_pkg::NO_TASK;
               blocked_ff <= 1'b1;
               tail_ff <= head_ff[s];
               if ({1'b0, head_ff[s]} >= 4'(NUM_TASKS)) head_ff[s] <= cur_ff;
            end
            pts_pkg::OP_WALK: begin
               if ({1'b0, walk_n} < 4'(NUM_TASKS)) tail_ff <= walk_n;
            end
            pts_pkg::OP_LINK: next_ff[tail_ff[TASK_IDX_W-1:0]] <= cur_ff;
            pts_pkg::OP_V: begin
               if (count_ff[s] != 8'sd127) begin
                  count_ff[s] <= count_ff[s] + 1'b1;
               end
               if (((count_ff[s] + 8'sd1) <= 8'sd0) && count_ff[s] != 8'sd127 &&
                   ({1'b0, v_head} < 4'(NUM_TASKS))) begin
                  head_ff[s] <= ({1'b0, v_next} < 4'(NUM_TASKS)) ? v_next : pts_pkg::NO_TASK;
                  next_ff[v_head[TASK_IDX_W-1:0]] <= pts_pkg::NO_TASK;
                  wait_ff[v_head[TASK_IDX_W-1:0]] <= 1'b0;
                  cur_ff <= v_head;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == pts_pkg::OP_DONE) begin
         out_task_ff <= cur_ff;
         out_none_ff <= none_ff;
         out_blocked_ff <= blocked_ff;
      end
   end

   function automatic logic [3:0] init_reset_nib(input int i);
      logic [15:0] v;
      v = 16'h1111;
      return v[4*i +: 4];
   endfunction
endmodule

// ===== sv/priority_tick_scheduler_semaphores_unit.sv =====
// Priority tick scheduler with counting semaphores for up to six tasks and four semaphores.
// One event is taken at a time and gives one result. A schedule decays the sleep counts,
// picks a ready task, refills the ready tasks and picks again if none was found, then
// commits; a sleep first sets the caller's sleep count. A V increments and wakes the head
// waiter; an ignored P or V goes straight to the result. A P decrements and, if it blocks,
// enqueues the caller (walking to the tail of a non-empty queue) and schedules. Result is
// held until taken; the next event is accepted the cycle after the result has gone.
module priority_tick_scheduler_semaphores_unit #(
   parameter int NUM_TASKS = pts_pkg::NUM_TASKS_DEF,
   parameter int NUM_SEMS = pts_pkg::NUM_SEMS_DEF
) (
   input logic                       clock,
   input logic                       reset,
   pts_if.sink                       req,
   pts_if.source                     rsp,
   input logic                       csr_write,
   input logic                       csr_index,
   input logic [pts_pkg::CSR_W-1:0]  csr_data
);
   pts_pkg::cmd_type    cmd;
   pts_pkg::status_type status;

   pts_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .status, .cmd
   );

   pts_dp #(.NUM_TASKS(NUM_TASKS), .NUM_SEMS(NUM_SEMS)) u_dp (
      .clock, .reset, .cmd, .status,
      .csr_write, .csr_index, .csr_data,
      .req_kind(req.payload.kind),
      .req_sem_index(req.payload.sem_index),
      .req_sleep_millis(req.payload.sleep_millis),
      .rsp_running_task(rsp.payload.running_task),
      .rsp_none_ready(rsp.payload.none_ready),
      .rsp_caller_blocked(rsp.payload.caller_blocked)
   );
endmodule

// ===== sv/pts_checker.sv =====
// port-level checker for the scheduler, bound to the top level
// uses nothing from pts_pkg; port widths are written out
module pts_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_running_task,
   input logic       rsp_none_ready,
   input logic       rsp_caller_blocked
);
   a_no_accept_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken with result pending");
   a_task_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_running_task < 3'd6) else $error("running task out of range");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_running_task))
      else $error("result changed while stalled");
   a_no_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid) else $error("result too early");
   a_blocked_scheduled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_caller_blocked && !rsp_none_ready |-> rsp_running_task < 3'd6)
      else $error("blocked without schedule");
endmodule

bind priority_tick_scheduler_semaphores_unit pts_checker u_checker (
   .clock, .reset,
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_running_task(rsp.payload.running_task),
   .rsp_none_ready(rsp.payload.none_ready),
   .rsp_caller_blocked(rsp.payload.caller_blocked)
);

// ===== bench/testbench.sv =====
// self-checking bench for priority_tick_scheduler_semaphores_unit
// needs pts_pkg, pts_if and the unit; predicts each result from its own copy of the state
// covers scheduling, sleep, semaphore P/V, register writes and back-pressure
module testbench;
   typedef struct packed {
      pts_pkg::kind_type kind;
      logic [1:0]        sem_index;
      logic [15:0]       sleep_millis;
   } sched_event_type;

   typedef struct packed {
      logic [2:0] running_task;
      logic       none_ready;
      logic       caller_blocked;
   } sched_result_type;

   localparam int NTASK = pts_pkg::NUM_TASKS_DEF;
   localparam int NSEM = pts_pkg::NUM_SEMS_DEF;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT = 600000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic csr_index = pts_pkg::CSR_PRIO;
   logic [pts_pkg::CSR_W-1:0] csr_data = '0;

   pts_if #(.payload_type(sched_event_type)) req_if ();
   pts_if #(.payload_type(sched_result_type)) rsp_if ();

   priority_tick_scheduler_semaphores_unit dut (
      .clock(clock), .reset(reset), .req(req_if), .rsp(rsp_if),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // scheduler state as predicted
   logic [pts_pkg::PRIO_W-1:0]  prio_reg;
   logic [pts_pkg::INIT_W-1:0]  init_reg;
   logic [pts_pkg::TICK_W-1:0]  ticks_left [NTASK];
   logic [pts_pkg::SLEEP_W-1:0] sleep_count [NTASK];
   logic                        blocked_on_sem [NTASK];
   logic [pts_pkg::TASK_W-1:0]  waiter_link [NTASK];
   int                          sem_value [NSEM];
   logic [pts_pkg::TASK_W-1:0]  waiter_head [NSEM];
   logic [pts_pkg::TASK_W-1:0]  running;

   sched_result_type pending_results [$];
   int  mismatches = 0;
   int  results_seen = 0;
   int  events_sent = 0;
   int  blocked_seen = 0;
   int  idle_seen = 0;
   int  cycles = 0;
   bit  quiet = 1'b0;
   int  stall_request = 0;

   always #1 clock = ~clock;

   function automatic void reload_counts();
      for (int i = 0; i < NSEM; i++) sem_value[i] = int'(init_reg[4*i +: 4]);
   endfunction

   function automatic int best_ready_task();
      int best;
      int top;
      best = -1;
      top = 0;
      for (int t = 0; t < NTASK; t++)
         if (!blocked_on_sem[t] && sleep_count[t] == 0 && int'(ticks_left[t]) > top) begin
            top = int'(ticks_left[t]);
            best = t;
         end
      return best;
   endfunction

   function automatic logic reschedule();
      int best;
      for (int t = 0; t < NTASK; t++)
         if (sleep_count[t] != 0) sleep_count[t]--;
      best = best_ready_task();
      if (best < 0) begin
         for (int t = 0; t < NTASK; t++)
            if (!blocked_on_sem[t] && sleep_count[t] == 0) ticks_left[t] = prio_reg[8*t +: 8];
         best = best_ready_task();
      end
      if (best < 0) return 1'b1;
      running = pts_pkg::TASK_W'(best);
      return 1'b0;
   endfunction

   function automatic sched_result_type apply_event(sched_event_type ev);
      sched_result_type r;
      int cur;
      int s;
      int tail;
      int h;
      r = '0;
      if (running >= NTASK) running = '0;
      cur = int'(running);
      s = int'(ev.sem_index);
      case (ev.kind)
         pts_pkg::KIND_SCHED: r.none_ready = reschedule();
         pts_pkg::KIND_SLEEP: begin
            sleep_count[cur] = pts_pkg::SLEEP_W'(ev.sleep_millis / pts_pkg::TICK_MS);
            r.none_ready = reschedule();
         end
         pts_pkg::KIND_P: begin
            if (s < NSEM && !blocked_on_sem[cur]) begin
               if (sem_value[s] > -128) sem_value[s]--;
               if (sem_value[s] < 0) begin
                  blocked_on_sem[cur] = 1'b1;
                  waiter_link[cur] = pts_pkg::NO_TASK;
                  if (waiter_head[s] >= NTASK) waiter_head[s] = pts_pkg::TASK_W'(cur);
                  else begin
                     tail = int'(waiter_head[s]);
                     for (int k = 0; k < NTASK; k++) begin
                        if (waiter_link[tail] >= NTASK) break;
                        tail = int'(waiter_link[tail]);
                     end
                     waiter_link[tail] = pts_pkg::TASK_W'(cur);
                  end
                  r.caller_blocked = 1'b1;
                  r.none_ready = reschedule();
               end
            end
         end
         default: begin
            if (s < NSEM) begin
               if (sem_value[s] < 127) sem_value[s]++;
               if (sem_value[s] <= 0 && waiter_head[s] < NTASK) begin
                  h = int'(waiter_head[s]);
                  waiter_head[s] = waiter_link[h] < NTASK ? waiter_link[h] : pts_pkg::NO_TASK;
                  waiter_link[h] = pts_pkg::NO_TASK;
                  blocked_on_sem[h] = 1'b0;
                  running = pts_pkg::TASK_W'(h);
               end
            end
         end
      endcase
      r.running_task = running;
      return r;
   endfunction

   // one transaction; valid stays high after acceptance until the next call
   task automatic send_event(pts_pkg::kind_type k, logic [1:0] s, logic [15:0] ms);
      sched_event_type ev;
      ev = '{kind: k, sem_index: s, sleep_millis: ms};
      @(negedge clock);
      while (!quiet && $urandom_range(99) < 17) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= ev;
      do @(posedge clock); while (!req_if.ready);
      pending_results.push_back(apply_event(ev));
      events_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic idx, logic [pts_pkg::CSR_W-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      if (idx == pts_pkg::CSR_PRIO) prio_reg = value[pts_pkg::PRIO_W-1:0];
      else begin
         init_reg = value[pts_pkg::INIT_W-1:0];
         reload_counts();
      end
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic random_event(int sleep_long_pct);
      logic [15:0] ms;
      int pick;
      pick = $urandom_range(99);
      ms = ($urandom_range(99) < sleep_long_pct) ? 16'($urandom) : 16'($urandom_range(60));
      if (pick < 30) send_event(pts_pkg::KIND_SCHED, 2'($urandom), 16'($urandom));
      else if (pick < 48) send_event(pts_pkg::KIND_SLEEP, 2'($urandom), ms);
      else if (pick < 74) send_event(pts_pkg::KIND_P, 2'($urandom), 16'($urandom));
      else send_event(pts_pkg::KIND_V, 2'($urandom), 16'($urandom));
   endtask

   task automatic test_directed();
      send_event(pts_pkg::KIND_SCHED, 2'd0, 16'd0);
      write_register(pts_pkg::CSR_PRIO, 48'h05_03_07_02_07_01);
      send_event(pts_pkg::KIND_SCHED, 2'd3, 16'hffff);
      send_event(pts_pkg::KIND_SLEEP, 2'd0, 16'd19);
      send_event(pts_pkg::KIND_SLEEP, 2'd0, 16'd20);
      send_event(pts_pkg::KIND_SLEEP, 2'd1, 16'd35);
      send_event(pts_pkg::KIND_SCHED, 2'd0, 16'd0);
      send_event(pts_pkg::KIND_P, 2'd0, 16'd0);
      send_event(pts_pkg::KIND_P, 2'd0, 16'd0);
      send_event(pts_pkg::KIND_P, 2'd0, 16'd0);
      send_event(pts_pkg::KIND_P, 2'd0, 16'd0);
      send_event(pts_pkg::KIND_V, 2'd0, 16'd0);
      send_event(pts_pkg::KIND_V, 2'd0, 16'd0);
      send_event(pts_pkg::KIND_V, 2'd0, 16'd0);
      send_event(pts_pkg::KIND_V, 2'd0, 16'd0);
      write_register(pts_pkg::CSR_INIT, 48'h0000);
      send_event(pts_pkg::KIND_P, 2'd2, 16'd0);
      send_event(pts_pkg::KIND_P, 2'd2, 16'd0);
      send_event(pts_pkg::KIND_SCHED, 2'd2, 16'd0);
      send_event(pts_pkg::KIND_V, 2'd3, 16'd0);
      send_event(pts_pkg::KIND_V, 2'd2, 16'd0);
      send_event(pts_pkg::KIND_V, 2'd2, 16'd0);
      write_register(pts_pkg::CSR_PRIO, '0);
      send_event(pts_pkg::KIND_SCHED, 2'd0, 16'd0);
      write_register(pts_pkg::CSR_PRIO, {pts_pkg::PRIO_W{1'b1}});
      send_event(pts_pkg::KIND_SLEEP, 2'd1, 16'hffff);
      send_event(pts_pkg::KIND_SCHED, 2'd1, 16'h8000);
   endtask

   task automatic test_count_saturation();
      write_register(pts_pkg::CSR_INIT, 48'hffff);
      for (int i = 0; i < 130; i++) send_event(pts_pkg::KIND_V, 2'd3, 16'($urandom));
      send_event(pts_pkg::KIND_P, 2'd3, 16'd0);
   endtask

   task automatic test_backpressure();
      stall_request = 300;
      for (int i = 0; i < 20; i++) random_event(0);
      wait_drained();
   endtask

   task automatic test_random(int n, logic [pts_pkg::PRIO_W-1:0] prio,
                              logic [pts_pkg::INIT_W-1:0] init, int sleep_long_pct);
      write_register(pts_pkg::CSR_PRIO, prio);
      write_register(pts_pkg::CSR_INIT, 48'(init));
      for (int i = 0; i < n; i++) random_event(sleep_long_pct);
   endtask

   // receiver with random idling and a long hold-off on request
   always @(negedge clock) begin
      static int stall_left = 0;
      if (stall_request > 0) begin
         stall_left = stall_request;
         stall_request = 0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else
         rsp_if.ready <= quiet || $urandom_range(99) >= 17;
   end

   always @(posedge clock) begin
      sched_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transaction %p", rsp_if.payload);
         end else begin
            want = pending_results.pop_front();
            if (want.caller_blocked) blocked_seen++;
            if (want.none_ready) idle_seen++;
            if (rsp_if.payload.running_task !== want.running_task ||
                rsp_if.payload.none_ready !== want.none_ready ||
                rsp_if.payload.caller_blocked !== want.caller_blocked) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: expected task %0d none %0b blocked %0b, got %0d %0b %0b",
                           results_seen, want.running_task, want.none_ready,
                           want.caller_blocked, rsp_if.payload.running_task,
                           rsp_if.payload.none_ready, rsp_if.payload.caller_blocked);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.payload = '0;
      prio_reg = '0;
      init_reg = 16'h1111;
      for (int t = 0; t < NTASK; t++) begin
         ticks_left[t] = '0;
         sleep_count[t] = '0;
         blocked_on_sem[t] = 1'b0;
         waiter_link[t] = pts_pkg::NO_TASK;
      end
      for (int i = 0; i < NSEM; i++) waiter_head[i] = pts_pkg::NO_TASK;
      reload_counts();
      running = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_count_saturation();
      test_backpressure();
      test_random(300, 48'h04_02_09_01_06_03, 16'h1201, 5);
      quiet = 1'b1;
      test_random(250, 48'($urandom) << 16 | 48'($urandom), 16'($urandom), 3);
      quiet = 1'b0;
      test_random(250, 48'h01_01_01_01_01_01, 16'h0000, 2);
      test_random(250, {pts_pkg::PRIO_W{1'b1}}, 16'hffff, 4);
      wait_drained();

      $display("%0d events sent, %0d results checked (%0d blocking P, %0d with no task ready)",
               events_sent, results_seen, blocked_seen, idle_seen);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
